FILE: design/btff_pkg.sv
// Shared types and constants of the boundary-tag first-fit allocator.
package btff_pkg;

    localparam int HEAP_WORDS = 4096;
    localparam int WORD_BYTES = 8;
    localparam int TAG_WORDS  = 2;
    localparam int AW         = $clog2(HEAP_WORDS);
    localparam int SW         = AW + 1;
    localparam int NW         = 14;
    localparam int BW         = 16;
    localparam int BYTE_SHIFT = $clog2(WORD_BYTES);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic ST_DONE  = 1'b0;
    localparam logic ST_NOFIT = 1'b1;

    typedef struct packed {
        logic          op;
        logic [NW-1:0] need;
        logic [AW-1:0] hdr;
        logic          pw_low;
    } t_cmd;

    typedef struct packed {
        logic          used;
        logic [SW-1:0] size;
    } t_tag;

endpackage

FILE: design/btff_front.sv
// Front end: accept requests, precompute word counts and header address, queue them.
module btff_front
    import btff_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic          i_opcode,
    input  logic [BW-1:0] i_request_bytes,
    input  logic [AW-1:0] i_payload_word,
    input  logic          i_busy,
    output logic          o_cmd_valid,
    output t_cmd          o_cmd,
    input  logic          i_cmd_pop
);

    t_cmd        r_q [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic        w_push;
    logic [BW:0] w_sum;
    t_cmd        w_cmd;

    assign o_in_stall  = i_busy || (r_cnt == 2'd2);
    assign w_push      = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    // round bytes plus both tags up to whole words
    assign w_sum = {1'b0, i_request_bytes}
                 + (BW+1)'(TAG_WORDS * WORD_BYTES + WORD_BYTES - 1);

    always_comb begin
        w_cmd.op     = i_opcode;
        w_cmd.need   = NW'(w_sum >> BYTE_SHIFT);
        w_cmd.hdr    = i_payload_word - AW'(1);
        w_cmd.pw_low = (i_payload_word < AW'(3));
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_cmd_pop);
        end
    end

endmodule

FILE: design/btff_back.sv
// Back end: tag memory, layout sweep, block walk and coalescing sequencer, result register.
module btff_back
    import btff_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [SW-1:0] i_end,
    input  logic          i_relayout,
    output logic          o_busy,
    input  logic          i_cmd_valid,
    input  t_cmd          i_cmd,
    output logic          o_cmd_pop,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic          o_status,
    output logic [AW-1:0] o_granted_word,
    output logic [SW-1:0] o_block_words
);

    typedef enum logic [11:0] {
        S_CLEAR = 12'b000000000001,
        S_IDLE  = 12'b000000000010,
        S_ARD   = 12'b000000000100,
        S_ACHK  = 12'b000000001000,
        S_AWF   = 12'b000000010000,
        S_F0    = 12'b000000100000,
        S_F1    = 12'b000001000000,
        S_F2    = 12'b000010000000,
        S_F3    = 12'b000100000000,
        S_FWH   = 12'b001000000000,
        S_FWF   = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } t_state;

    t_tag          r_mem [HEAP_WORDS];
    t_tag          r_rd;
    t_state        r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    logic [SW-1:0] r_hdr, n_hdr;
    logic [SW-1:0] r_size, n_size;
    logic [SW-1:0] r_start, n_start;
    logic [SW-1:0] r_total, n_total;
    logic [NW-1:0] r_need, n_need;
    logic          r_pw_low, n_pw_low;
    logic          r_st, n_st;
    logic [AW-1:0] r_gw, n_gw;
    logic [SW-1:0] r_bw, n_bw;
    logic          r_out_valid, n_out_valid;
    logic          r_status, n_status;
    logic [AW-1:0] r_granted, n_granted;
    logic [SW-1:0] r_blk, n_blk;
    logic          w_we;
    logic [AW-1:0] w_wa;
    t_tag          w_wd;
    logic [AW-1:0] w_ra;
    t_tag          w_clr_val;
    logic [SW-1:0] w_rh;
    logic [SW-1:0] w_sum;

    assign o_busy         = (r_state == S_CLEAR);
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_granted_word = r_granted;
    assign o_block_words  = r_blk;
    assign w_rh           = r_hdr + r_size;

    always_comb begin
        w_clr_val = '0;
        if (r_clr == AW'(0) || r_clr == AW'(1)) begin
            w_clr_val = '{used: 1'b1, size: SW'(2)};
        end else if (r_clr == AW'(2) || {1'b0, r_clr} == i_end - SW'(1)) begin
            w_clr_val = '{used: 1'b0, size: i_end - SW'(2)};
        end
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_hdr       = r_hdr;
        n_size      = r_size;
        n_start     = r_start;
        n_total     = r_total;
        n_need      = r_need;
        n_pw_low    = r_pw_low;
        n_st        = r_st;
        n_gw        = r_gw;
        n_bw        = r_bw;
        n_out_valid = r_out_valid && i_out_stall;
        n_status    = r_status;
        n_granted   = r_granted;
        n_blk       = r_blk;
        w_we        = 1'b0;
        w_wa        = r_clr;
        w_wd        = w_clr_val;
        w_ra        = r_hdr[AW-1:0];
        w_sum       = r_start + r_total - SW'(1);
        o_cmd_pop   = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                w_we  = 1'b1;
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(HEAP_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_need    = i_cmd.need;
                    n_pw_low  = i_cmd.pw_low;
                    if (i_cmd.op == OP_ALLOC) begin
                        n_hdr   = '0;
                        n_state = S_ARD;
                    end else begin
                        n_hdr   = {1'b0, i_cmd.hdr};
                        n_state = S_F0;
                    end
                end
            end
            S_ARD: begin
                if (r_hdr >= i_end) begin
                    n_st    = ST_NOFIT;
                    n_gw    = '0;
                    n_bw    = '0;
                    n_state = S_OUT;
                end else begin
                    n_state = S_ACHK;
                end
            end
            S_ACHK: begin
                if (r_rd.size == '0 || r_rd.size > i_end - r_hdr) begin
                    n_st    = ST_NOFIT;
                    n_gw    = '0;
                    n_bw    = '0;
                    n_state = S_OUT;
                end else if (!r_rd.used && {1'b0, r_rd.size} >= r_need) begin
                    w_we    = 1'b1;
                    w_wa    = r_hdr[AW-1:0];
                    w_wd    = '{used: 1'b1, size: r_rd.size};
                    n_size  = r_rd.size;
                    n_state = S_AWF;
                end else begin
                    n_hdr   = r_hdr + r_rd.size;
                    n_state = S_ARD;
                end
            end
            S_AWF: begin
                w_sum   = r_hdr + r_size - SW'(1);
                w_we    = 1'b1;
                w_wa    = w_sum[AW-1:0];
                w_wd    = '{used: 1'b1, size: r_size};
                n_st    = ST_DONE;
                n_gw    = r_hdr[AW-1:0] + AW'(1);
                n_bw    = r_size;
                n_state = S_OUT;
            end
            S_F0: begin
                if (r_pw_low || r_hdr >= i_end) begin
                    n_st    = ST_DONE;
                    n_gw    = '0;
                    n_bw    = '0;
                    n_state = S_OUT;
                end else begin
                    n_state = S_F1;
                end
            end
            S_F1: begin
                if (!r_rd.used || r_rd.size < SW'(2) || r_rd.size > i_end - r_hdr) begin
                    n_st    = ST_DONE;
                    n_gw    = '0;
                    n_bw    = '0;
                    n_state = S_OUT;
                end else begin
                    n_size  = r_rd.size;
                    n_start = r_hdr;
                    n_total = r_rd.size;
                    w_ra    = r_hdr[AW-1:0] - AW'(1);
                    n_state = S_F2;
                end
            end
            S_F2: begin
                // left neighbor footer
                if (!r_rd.used && r_rd.size >= SW'(2) && r_rd.size <= r_hdr - SW'(2)) begin
                    n_start = r_hdr - r_rd.size;
                    n_total = r_total + r_rd.size;
                end
                if (w_rh < i_end) begin
                    w_ra    = w_rh[AW-1:0];
                    n_state = S_F3;
                end else begin
                    n_state = S_FWH;
                end
            end
            S_F3: begin
                // right neighbor header
                if (!r_rd.used && r_rd.size >= SW'(2) && r_rd.size <= i_end - w_rh) begin
                    n_total = r_total + r_rd.size;
                end
                n_state = S_FWH;
            end
            S_FWH: begin
                w_we    = 1'b1;
                w_wa    = r_start[AW-1:0];
                w_wd    = '{used: 1'b0, size: r_total};
                n_state = S_FWF;
            end
            S_FWF: begin
                w_we    = 1'b1;
                w_wa    = w_sum[AW-1:0];
                w_wd    = '{used: 1'b0, size: r_total};
                n_st    = ST_DONE;
                n_gw    = '0;
                n_bw    = r_total;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_status    = r_st;
                    n_granted   = r_gw;
                    n_blk       = r_bw;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (i_relayout) begin
            n_state = S_CLEAR;
            n_clr   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd <= r_mem[w_ra];
    end

    always_ff @(posedge i_clk) begin
        r_hdr     <= n_hdr;
        r_size    <= n_size;
        r_start   <= n_start;
        r_total   <= n_total;
        r_need    <= n_need;
        r_pw_low  <= n_pw_low;
        r_st      <= n_st;
        r_gw      <= n_gw;
        r_bw      <= n_bw;
        r_status  <= n_status;
        r_granted <= n_granted;
        r_blk     <= n_blk;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: design/boundary_tag_first_fit_allocator_core.sv
// Top level of the boundary-tag first-fit heap allocator.
// Boundary-tag heap allocator over a 4096-word tag memory. Each block carries a header
// and a footer tag (used bit, size in words). An allocate rounds request_bytes plus two
// tag words up to whole words and walks the blocks first-fit from word 0, taking the first
// large-enough free block whole; a free merges with free neighbors on both sides. An
// allocate reads and checks each block it visits (S_ARD, S_ACHK), then writes the footer
// (S_AWF); the registered tag memory read in the walk loop sets its pace. After reset and
// after every write of heap_end_word the block sweeps the whole tag memory to lay down the
// prologue and one free block, and holds o_in_stall high meanwhile. A two-entry queue
// decouples request acceptance from the sequencer, and a result register holds each
// transfer until taken.
module boundary_tag_first_fit_allocator_core
    import btff_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic [SW-1:0] i_cfg_wr_data,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic          i_opcode,
    input  logic [BW-1:0] i_request_bytes,
    input  logic [AW-1:0] i_payload_word,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic          o_status,
    output logic [AW-1:0] o_granted_word,
    output logic [SW-1:0] o_block_words
);

    logic [SW-1:0] r_heap_end_word;
    logic [SW-1:0] w_end;
    logic          w_busy;
    logic          w_cmd_valid;
    logic          w_cmd_pop;
    t_cmd          w_cmd;

    // hold the configured end; the sequencer reruns layout on each write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_end_word <= SW'(HEAP_WORDS);
        end else if (i_cfg_wr_en) begin
            r_heap_end_word <= i_cfg_wr_data;
        end
    end

    // clamp the effective end to [4, HEAP_WORDS]
    always_comb begin
        w_end = r_heap_end_word;
        if (r_heap_end_word < SW'(4)) begin
            w_end = SW'(4);
        end else if (r_heap_end_word > SW'(HEAP_WORDS)) begin
            w_end = SW'(HEAP_WORDS);
        end
    end

    btff_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_opcode        (i_opcode),
        .i_request_bytes (i_request_bytes),
        .i_payload_word  (i_payload_word),
        .i_busy          (w_busy),
        .o_cmd_valid     (w_cmd_valid),
        .o_cmd           (w_cmd),
        .i_cmd_pop       (w_cmd_pop)
    );

    btff_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_end          (w_end),
        .i_relayout     (i_cfg_wr_en),
        .o_busy         (w_busy),
        .i_cmd_valid    (w_cmd_valid),
        .i_cmd          (w_cmd),
        .o_cmd_pop      (w_cmd_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_granted_word (o_granted_word),
        .o_block_words  (o_block_words)
    );

    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en |=> w_busy)
        else $error("layout sweep did not start after a config write");

    a_nofit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_NOFIT) |-> (o_granted_word == '0 && o_block_words == '0))
        else $error("no-fit result carries nonzero fields");

    a_grant_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_granted_word != '0) |-> (o_block_words >= SW'(2)))
        else $error("granted block smaller than two words");

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the boundary-tag first-fit heap allocator core.
`timescale 1ns / 100ps

module tb_top
    import btff_pkg::*;
;

    // Stop the run here if the results never come; a correct run needs far less.
    localparam int CYCLE_LIMIT = 20000000;
    // Long receiver hold-off, long enough to fill the request queue.
    localparam int LONG_HOLD   = 300;
    // Settle time after the last result before a register write or the end.
    localparam int SETTLE      = 64;

    typedef struct packed {
        logic          status;
        logic [AW-1:0] granted_word;
        logic [SW-1:0] block_words;
    } t_heap_result;

    typedef struct {
        logic          op;
        logic [BW-1:0] nbytes;
        logic [AW-1:0] pword;
        bit            typed;
        t_heap_result  res;
    } t_heap_row;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_cfg_wr_en = 1'b0;
    logic [SW-1:0] i_cfg_wr_data = '0;
    logic          i_in_valid = 1'b0;
    logic          o_in_stall;
    logic          i_opcode = OP_ALLOC;
    logic [BW-1:0] i_request_bytes = '0;
    logic [AW-1:0] i_payload_word = '0;
    logic          o_out_valid;
    logic          i_out_stall = 1'b0;
    logic          o_status;
    logic [AW-1:0] o_granted_word;
    logic [SW-1:0] o_block_words;

    boundary_tag_first_fit_allocator_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_opcode       (i_opcode),
        .i_request_bytes(i_request_bytes),
        .i_payload_word (i_payload_word),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_granted_word (o_granted_word),
        .o_block_words  (o_block_words)
    );

    always #1 i_clk = ~i_clk;

    // Shadow copy of the tag memory: used bit and size per word.
    bit          tag_used [HEAP_WORDS];
    int unsigned tag_size [HEAP_WORDS];
    int unsigned heap_end_reg;

    t_heap_result pending_results[$];
    logic [AW-1:0] live_blocks[$];   // payload words currently granted

    int err_cnt;
    int cycle_cnt;
    int src_idle_pct;
    int sink_stall_pct;
    int hold_cnt;
    int n_sent, n_grants, n_nofit, n_merges, n_ignored, n_checked;

    // Effective heap end: register clamped to [4, HEAP_WORDS].
    function automatic int unsigned heap_limit();
        if (heap_end_reg < 4) return 4;
        if (heap_end_reg > HEAP_WORDS) return HEAP_WORDS;
        return heap_end_reg;
    endfunction

    function automatic void mark_block(int unsigned hdr, int unsigned size, bit used);
        int unsigned ftr;
        ftr = hdr + size - 1;
        if (hdr < HEAP_WORDS) begin
            tag_used[hdr] = used;
            tag_size[hdr] = size;
        end
        if (ftr < HEAP_WORDS) begin
            tag_used[ftr] = used;
            tag_size[ftr] = size;
        end
    endfunction

    // Rebuild the heap: used prologue, then one free block to the end.
    function automatic void rebuild_heap();
        for (int i = 0; i < HEAP_WORDS; i++) begin
            tag_used[i] = 1'b0;
            tag_size[i] = 0;
        end
        mark_block(0, 2, 1'b1);
        mark_block(2, heap_limit() - 2, 1'b0);
    endfunction

    function automatic t_heap_result first_fit_alloc(logic [BW-1:0] nbytes);
        t_heap_result r;
        int unsigned e, need, hdr, sz;
        e = heap_limit();
        need = (int'(nbytes) + TAG_WORDS * WORD_BYTES + WORD_BYTES - 1) / WORD_BYTES;
        hdr = 0;
        r = '{status: ST_NOFIT, granted_word: '0, block_words: '0};
        while (hdr < e) begin
            sz = tag_size[hdr];
            if (sz == 0 || sz > e - hdr) break;
            if (!tag_used[hdr] && sz >= need) begin
                mark_block(hdr, sz, 1'b1);
                r.status = ST_DONE;
                r.granted_word = AW'(hdr + 1);
                r.block_words = SW'(sz);
                return r;
            end
            hdr += sz;
        end
        return r;
    endfunction

    function automatic t_heap_result coalescing_free(logic [AW-1:0] pword);
        t_heap_result r;
        int unsigned e, hdr, size, start, total, ls, rs, rh;
        e = heap_limit();
        r = '{status: ST_DONE, granted_word: '0, block_words: '0};
        // Drop frees of bad headers.
        if (pword < 3 || pword - 1 >= e) return r;
        hdr = pword - 1;
        size = tag_size[hdr];
        if (!tag_used[hdr] || size < 2 || size > e - hdr) return r;
        start = hdr;
        total = size;
        // Merge left neighbor if free and plausible.
        if (!tag_used[hdr - 1]) begin
            ls = tag_size[hdr - 1];
            if (ls >= 2 && ls <= hdr - 2) begin
                start = hdr - ls;
                total += ls;
            end
        end
        // Merge right neighbor; the heap end counts as used.
        rh = hdr + size;
        if (rh < e && !tag_used[rh]) begin
            rs = tag_size[rh];
            if (rs >= 2 && rs <= e - rh) total += rs;
        end
        mark_block(start, total, 1'b0);
        r.block_words = SW'(total);
        return r;
    endfunction

    function automatic t_heap_result predict_heap_op(logic op, logic [BW-1:0] nbytes,
                                                     logic [AW-1:0] pword);
        if (op == OP_FREE) return coalescing_free(pword);
        return first_fit_alloc(nbytes);
    endfunction

    // Run the cycle counter and stop on timeout.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Drive receiver stall at the falling edge; a pending long hold wins.
    always @(negedge i_clk) begin
        if (hold_cnt > 0) begin
            i_out_stall = 1'b1;
            hold_cnt = hold_cnt - 1;
        end else begin
            i_out_stall = ($urandom_range(99) < sink_stall_pct);
        end
    end

    // Check each result transfer against the oldest expectation.
    always @(posedge i_clk) begin
        t_heap_result exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d granted_word %0d block_words %0d",
                       o_status, o_granted_word, o_block_words);
                err_cnt++;
            end else begin
                exp_r = pending_results.pop_front();
                n_checked++;
                if (o_status !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, o_status);
                    err_cnt++;
                end
                if (o_granted_word !== exp_r.granted_word) begin
                    $error("granted_word: expected %0d, got %0d",
                           exp_r.granted_word, o_granted_word);
                    err_cnt++;
                end
                if (o_block_words !== exp_r.block_words) begin
                    $error("block_words: expected %0d, got %0d",
                           exp_r.block_words, o_block_words);
                    err_cnt++;
                end
            end
        end
    end

    // Offer one request, hold it until the transfer, then predict its result.
    task automatic send_request(logic op, logic [BW-1:0] nbytes, logic [AW-1:0] pword,
                                bit typed, t_heap_result typed_res);
        t_heap_result r;
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_opcode = op;
        i_request_bytes = nbytes;
        i_payload_word = pword;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        r = predict_heap_op(op, nbytes, pword);
        pending_results.push_back(typed ? typed_res : r);
        n_sent++;
        if (op == OP_ALLOC && r.status == ST_DONE) begin
            live_blocks.push_back(r.granted_word);
            n_grants++;
        end
        if (op == OP_ALLOC && r.status == ST_NOFIT) n_nofit++;
        if (op == OP_FREE && r.block_words != 0) n_merges++;
        if (op == OP_FREE && r.block_words == 0) n_ignored++;
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // Wait for every expected result, then let the block settle.
    task automatic drain_results();
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // Write the heap end while idle; this also resets the heap layout.
    task automatic write_heap_end(logic [SW-1:0] value);
        drain_results();
        i_cfg_wr_data = value;
        i_cfg_wr_en = 1'b1;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        heap_end_reg = value;
        rebuild_heap();
        live_blocks.delete();
    endtask

    // One random request: mostly sized allocs and frees of granted blocks,
    // the rest frees of arbitrary words.
    task automatic send_random();
        int unsigned sel, e, k;
        logic [BW-1:0] nb;
        logic [AW-1:0] pw;
        t_heap_result none;
        none = '0;
        e = heap_limit();
        sel = $urandom_range(99);
        nb = BW'($urandom);
        pw = AW'($urandom);
        if (sel < 45) begin
            if ($urandom_range(9) != 0) nb = BW'($urandom_range(0, e * WORD_BYTES));
            send_request(OP_ALLOC, nb, pw, 1'b0, none);
        end else if (sel < 75 && live_blocks.size() != 0) begin
            k = $urandom_range(live_blocks.size() - 1);
            pw = live_blocks[k];
            live_blocks.delete(k);
            send_request(OP_FREE, nb, pw, 1'b0, none);
        end else begin
            if ($urandom_range(1)) pw = AW'($urandom_range(0, e + 1));
            send_request(OP_FREE, nb, pw, 1'b0, none);
        end
    endtask

    // Directed rows after reset (heap end 4096); typed rows give the result.
    t_heap_row directed_rows[] = '{
        '{OP_ALLOC, 16'd0,     12'd0,    1'b1, '{ST_DONE,  12'd3, 13'd4094}},
        '{OP_ALLOC, 16'd1,     12'd4095, 1'b1, '{ST_NOFIT, 12'd0, 13'd0}},
        '{OP_FREE,  16'hFFFF,  12'd3,    1'b1, '{ST_DONE,  12'd0, 13'd4094}},
        '{OP_FREE,  16'd0,     12'd3,    1'b1, '{ST_DONE,  12'd0, 13'd0}},
        '{OP_FREE,  16'd0,     12'd0,    1'b1, '{ST_DONE,  12'd0, 13'd0}},
        '{OP_FREE,  16'd0,     12'd4095, 1'b1, '{ST_DONE,  12'd0, 13'd0}},
        '{OP_ALLOC, 16'hFFFF,  12'd0,    1'b1, '{ST_NOFIT, 12'd0, 13'd0}},
        '{OP_ALLOC, 16'd32752, 12'd0,    1'b1, '{ST_NOFIT, 12'd0, 13'd0}},
        '{OP_ALLOC, 16'd32736, 12'd0,    1'b1, '{ST_DONE,  12'd3, 13'd4094}},
        '{OP_FREE,  16'd0,     12'd2,    1'b1, '{ST_DONE,  12'd0, 13'd0}},
        '{OP_FREE,  16'd0,     12'd4095, 1'b0, '0},
        '{OP_FREE,  16'd0,     12'd3,    1'b1, '{ST_DONE,  12'd0, 13'd4094}},
        '{OP_ALLOC, 16'd32768, 12'd0,    1'b1, '{ST_NOFIT, 12'd0, 13'd0}},
        '{OP_ALLOC, 16'd8,     12'd0,    1'b0, '0},
        '{OP_FREE,  16'd0,     12'd4094, 1'b0, '0},
        '{OP_FREE,  16'd0,     12'd3,    1'b0, '0},
        '{OP_FREE,  16'd0,     12'd3,    1'b0, '0},
        '{OP_ALLOC, 16'd100,   12'd0,    1'b0, '0}
    };

    // Heap end per random phase: clamped low, clamped high, extremes, mid sizes.
    logic [SW-1:0] phase_ends[] = '{13'd0, 13'h1FFF, 13'd4, 13'd37, 13'd300, 13'd4096};

    initial begin
        err_cnt = 0;
        cycle_cnt = 0;
        hold_cnt = 0;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        heap_end_reg = HEAP_WORDS;
        rebuild_heap();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].op, directed_rows[i].nbytes,
                         directed_rows[i].pword, directed_rows[i].typed,
                         directed_rows[i].res);

        for (int p = 0; p < phase_ends.size(); p++) begin
            write_heap_end(phase_ends[p]);
            case (p % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 52; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 52; end
                default: begin src_idle_pct = 20; sink_stall_pct = 20; end
            endcase
            for (int n = 0; n < 82; n++) begin
                // Hold off the receiver while requests keep coming.
                if (p == 1 && n == 20) hold_cnt = LONG_HOLD;
                // Pause the sender until the block has answered everything.
                if (p == 3 && n == 40)
                    while (pending_results.size() != 0) @(negedge i_clk);
                send_random();
            end
        end

        src_idle_pct = 0;
        sink_stall_pct = 0;
        drain_results();

        $display("Sent %0d requests over %0d heap sizes; %0d results checked.",
                 n_sent, phase_ends.size() + 1, n_checked);
        $display("Grants %0d, no-fit %0d, merging frees %0d, ignored frees %0d.",
                 n_grants, n_nofit, n_merges, n_ignored);
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/btff_pkg.sv
design/btff_front.sv
design/btff_back.sv
design/boundary_tag_first_fit_allocator_core.sv
tb/tb_top.sv
